// ===== src/mm_pkg.sv =====
// Shared types, codes and helpers for the matrix multiply block.
// Used by mm_front, mm_queue, mm_back and the top level; no dependencies.
`timescale 1ns / 1ps

package mm_pkg;

  // Fixed field widths
  localparam int DIM_W       = 5;
  localparam int IDX_W       = 4;
  localparam int ELEM_W      = 16;
  localparam int PROD_W      = 2 * ELEM_W;
  localparam int SUM_W       = 38;
  localparam int OP_W        = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int DEF_MAX_DIM = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_A = 2'd0,
    REG_INNER  = 2'd1,
    REG_COLS_B = 2'd2
  } cfg_reg_t;

  // Operation codes of an input item
  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_ROW    = 2'd2
  } op_t;

  // Work handed from the front to the back
  typedef enum logic [1:0] {
    CMD_LOAD_A,
    CMD_LOAD_B,
    CMD_ROW,
    CMD_BAD_ROW
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic [ELEM_W-1:0]  value;
  } cmd_t;

  // Effective sizes of the product
  typedef struct packed {
    logic [DIM_W-1:0] m;
    logic [DIM_W-1:0] k;
    logic [DIM_W-1:0] n;
  } dims_t;

  // Zero acts as one, anything above the limit acts as the limit
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = 5'd1;
    else if (v > lim) r = lim;
    return r;
  endfunction

endpackage

// ===== src/matrix_multiply.sv =====
// Top level of the fixed-point matrix multiply C = A x B.
// Depends on mm_pkg, mm_front, mm_queue and mm_back.
`timescale 1ns / 1ps
//
// Usage:
//   Configuration: cfg_write with cfg_index 0, 1, 2 sets rows_a, inner_size and
//   cols_b (M, K, N); write only while the block is idle.
//   Input channel (in_valid/in_ready): operation 0 loads A[row][col], 1 loads
//   B[row][col], 2 asks for product row "row". Loads outside the sizes and
//   operation 3 are dropped.
//   Output channel (out_valid/out_ready): a row request gives N results in
//   column order, the final one with last set. A row at or beyond M gives one
//   result with bad_request, last set and sum zero.
//   Back end: a load is written to its element store. For a row request,
//   one shared multiply-accumulate takes one term a cycle, with a read,
//   multiply and add stage drained per column.
//   A four-entry command queue lets the input keep accepting while the
//   back end works; in_ready drops only when that queue is full.
//   Receiver stall: the result register holds its item and the back end
//   waits before the next column; the queue then fills and in_ready drops.
//   Reset: sizes return to 16, queue and result register empty. The element
//   stores are not cleared; read only elements that were loaded.
//
module matrix_multiply import mm_pkg::*; #(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DIM_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_W-1:0]          operation,
  input  logic [IDX_W-1:0]         row,
  input  logic [IDX_W-1:0]         col,
  input  logic signed [ELEM_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [IDX_W-1:0]         out_col,
  output logic signed [SUM_W-1:0]  sum,
  output logic                     last,
  output logic                     bad_request
);

  logic  push;
  cmd_t  push_cmd;
  dims_t dims;
  logic  pop;
  cmd_t  head;
  logic  q_empty;
  logic  q_full;

  // Accept and classify items
  mm_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .row       (row),
    .col       (col),
    .value     (value),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd),
    .dims      (dims)
  );

  // Decouple front and back
  mm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Carry out loads and row requests
  mm_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk         (clk),
    .rst         (rst),
    .dims        (dims),
    .head        (head),
    .empty       (q_empty),
    .pop         (pop),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_col     (out_col),
    .sum         (sum),
    .last        (last),
    .bad_request (bad_request)
  );

endmodule

// ===== src/mm_front.sv =====
// Front end: configuration registers, input handshake and item classification.
// Depends on mm_pkg.
`timescale 1ns / 1ps

module mm_front import mm_pkg::*; #(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      operation,
  input  logic [IDX_W-1:0]     row,
  input  logic [IDX_W-1:0]     col,
  input  logic [ELEM_W-1:0]    value,
  input  logic                 q_full,
  output logic                 push,
  output cmd_t                 push_cmd,
  output dims_t                dims
);

  localparam int DIM_LIM = (MAX_DIM < 16) ? MAX_DIM : 16;

  logic [DIM_W-1:0] rows_a;
  logic [DIM_W-1:0] inner_size;
  logic [DIM_W-1:0] cols_b;
  logic             keep;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a     <= DIM_RESET;
      inner_size <= DIM_RESET;
      cols_b     <= DIM_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROWS_A: rows_a     <= cfg_data;
        REG_INNER:  inner_size <= cfg_data;
        REG_COLS_B: cols_b     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp sizes to what the stores hold
  always_comb begin
    dims.m = eff_dim(rows_a, DIM_W'(DIM_LIM));
    dims.k = eff_dim(inner_size, DIM_W'(DIM_LIM));
    dims.n = eff_dim(cols_b, DIM_W'(DIM_LIM));
  end

  // Classify the item; drop loads outside the size and unused operations
  always_comb begin
    push_cmd.row   = row;
    push_cmd.col   = col;
    push_cmd.value = value;
    push_cmd.kind  = CMD_LOAD_A;
    keep           = 1'b0;
    case (operation)
      OP_LOAD_A: begin
        push_cmd.kind = CMD_LOAD_A;
        keep = ({1'b0, row} < dims.m) && ({1'b0, col} < dims.k);
      end
      OP_LOAD_B: begin
        push_cmd.kind = CMD_LOAD_B;
        keep = ({1'b0, row} < dims.k) && ({1'b0, col} < dims.n);
      end
      OP_ROW: begin
        push_cmd.kind = ({1'b0, row} < dims.m) ? CMD_ROW : CMD_BAD_ROW;
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready && keep;

endmodule

// ===== src/mm_queue.sv =====
// Short command queue between the front and the back end.
// Depends on mm_pkg.
`timescale 1ns / 1ps

module mm_queue import mm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CW'(QUEUE_DEPTH));
  assign head  = entries[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  // Advance pointers and track fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ===== src/mm_back.sv =====
// Back end: element stores, shared multiply-accumulate and result register.
// Depends on mm_pkg.
`timescale 1ns / 1ps

module mm_back import mm_pkg::*; #(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  logic                     clk,
  input  logic                     rst,
  input  dims_t                    dims,
  input  cmd_t                     head,
  input  logic                     empty,
  output logic                     pop,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic [IDX_W-1:0]         out_col,
  output logic signed [SUM_W-1:0]  sum,
  output logic                     last,
  output logic                     bad_request
);

  localparam int DIM_LIM = (MAX_DIM < 16) ? MAX_DIM : 16;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int AW      = $clog2(DEPTH);
  localparam int IW      = $clog2(DIM_LIM);

  typedef enum logic [1:0] {
    IDLE,
    ISSUE,
    DRAIN,
    PUT
  } state_t;

  state_t                    state;
  logic [ELEM_W-1:0]         a_store [DEPTH];
  logic [ELEM_W-1:0]         b_store [DEPTH];
  logic [IDX_W-1:0]          cur_row;
  logic [IW-1:0]             t;
  logic [IW-1:0]             j;
  logic [IW-1:0]             k_last;
  logic [IW-1:0]             n_last;
  logic [AW-1:0]             wr_addr;
  logic [AW-1:0]             a_rd;
  logic [AW-1:0]             b_rd;
  logic                      issue;
  logic                      out_free;
  logic                      put_item;
  logic                      we_a;
  logic                      we_b;
  logic signed [ELEM_W-1:0]  a_q;
  logic signed [ELEM_W-1:0]  b_q;
  logic                      rd_v;
  logic                      rd_first;
  logic                      rd_last;
  logic signed [PROD_W-1:0]  prod;
  logic                      mul_v;
  logic                      mul_first;
  logic                      mul_last;
  logic signed [SUM_W-1:0]   acc;

  assign k_last   = IW'(dims.k - 5'd1);
  assign n_last   = IW'(dims.n - 5'd1);
  assign wr_addr  = AW'(int'(head.row) * MAX_DIM + int'(head.col));
  assign a_rd     = AW'(int'(cur_row) * MAX_DIM + int'(t));
  assign b_rd     = AW'(int'(t) * MAX_DIM + int'(j));
  assign issue    = (state == ISSUE);
  assign out_free = !out_valid || out_ready;
  assign pop      = (state == IDLE) && !empty &&
                    ((head.kind != CMD_BAD_ROW) || out_free);
  assign we_a     = pop && (head.kind == CMD_LOAD_A);
  assign we_b     = pop && (head.kind == CMD_LOAD_B);
  assign put_item = (pop && (head.kind == CMD_BAD_ROW)) || ((state == PUT) && out_free);

  // A store: load writes, row term reads
  always_ff @(posedge clk) begin
    if (we_a) a_store[wr_addr] <= head.value;
    if (issue) a_q <= a_store[a_rd];
  end

  // B store: load writes, column term reads
  always_ff @(posedge clk) begin
    if (we_b) b_store[wr_addr] <= head.value;
    if (issue) b_q <= b_store[b_rd];
  end

  // Multiply, then accumulate; restart the sum on each column's first term
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v  <= 1'b0;
      mul_v <= 1'b0;
    end else begin
      rd_v  <= issue;
      mul_v <= rd_v;
    end
    rd_first  <= (t == '0);
    rd_last   <= (t == k_last);
    mul_first <= rd_first;
    mul_last  <= rd_last;
    prod      <= a_q * b_q;
    if (mul_v) acc <= (mul_first ? '0 : acc) + SUM_W'(prod);
  end

  // Sequence one row request, column by column, or put out a bad-row result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      t         <= '0;
      j         <= '0;
    end else begin
      if (out_valid && out_ready && !put_item) out_valid <= 1'b0;
      case (state)
        IDLE: begin
          if (pop) begin
            if (head.kind == CMD_BAD_ROW) begin
              out_valid   <= 1'b1;
              out_col     <= '0;
              sum         <= '0;
              last        <= 1'b1;
              bad_request <= 1'b1;
            end else if (head.kind == CMD_ROW) begin
              cur_row <= head.row;
              t       <= '0;
              j       <= '0;
              state   <= ISSUE;
            end
          end
        end
        ISSUE: begin
          if (t == k_last) begin
            t     <= '0;
            state <= DRAIN;
          end else begin
            t <= t + 1'b1;
          end
        end
        DRAIN: begin
          if (mul_v && mul_last) state <= PUT;
        end
        PUT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_col     <= IDX_W'(j);
            sum         <= acc;
            last        <= (j == n_last);
            bad_request <= 1'b0;
            if (j == n_last) begin
              state <= IDLE;
            end else begin
              j     <= j + 1'b1;
              state <= ISSUE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== src/mm_checker.sv =====
// Port-level checks for matrix_multiply, bound to the top level.
// Depends on mm_pkg and matrix_multiply.
`timescale 1ns / 1ps

module mm_checker import mm_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [IDX_W-1:0]         out_col,
  input logic signed [SUM_W-1:0]  sum,
  input logic                     last,
  input logic                     bad_request
);

  // Reset leaves the queue empty and no result pending
  a_reset_clear: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("queue or result register not cleared by reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_col) && $stable(sum) &&
                                $stable(last) && $stable(bad_request))
    else $error("stalled result changed");

  // A flagged row gives a single zero result in column zero
  a_bad_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_request |-> last && sum == '0 && out_col == '0)
    else $error("bad row result malformed");

  // The highest column always closes a row
  a_col_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_col == {IDX_W{1'b1}} |-> last)
    else $error("highest column not marked last");

endmodule

bind matrix_multiply mm_checker u_mm_checker (.*);
